/* hdl/pdc_pkg.sv */
// pdc_pkg: shared types and constants of the pid position/delta controller
// configuration register indexes, reset values, status codes, config bundle
// no dependencies
package pdc_pkg;

	localparam int GAIN_W    = 24;
	localparam int LIMIT_W   = 15;
	localparam int WINDOW_W  = 16;
	localparam int DRIVE_W   = 16;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DW    = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P     = 3'd0,
		REG_GAIN_I     = 3'd1,
		REG_GAIN_D     = 3'd2,
		REG_LOOP_MODE  = 3'd3,
		REG_MAX_OUTPUT = 3'd4,
		REG_INT_LIMIT  = 3'd5,
		REG_ERR_WINDOW = 3'd6,
		REG_DEAD_ZONE  = 3'd7
	} reg_idx_t;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_WINDOW    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_DEAD_ZONE = 2'd2;

	localparam logic [GAIN_W-1:0]   RST_GAIN_P     = 24'd150733;
	localparam logic [GAIN_W-1:0]   RST_GAIN_I     = 24'd655;
	localparam logic [GAIN_W-1:0]   RST_GAIN_D     = 24'd0;
	localparam logic                RST_LOOP_MODE  = 1'b0;
	localparam logic [LIMIT_W-1:0]  RST_MAX_OUTPUT = 15'd20000;
	localparam logic [LIMIT_W-1:0]  RST_INT_LIMIT  = 15'd5000;
	localparam logic [WINDOW_W-1:0] RST_ERR_WINDOW = 16'd0;
	localparam logic [WINDOW_W-1:0] RST_DEAD_ZONE  = 16'd0;

	typedef struct packed {
		logic signed [GAIN_W-1:0] gain_p;
		logic signed [GAIN_W-1:0] gain_i;
		logic signed [GAIN_W-1:0] gain_d;
		logic                     loop_mode;
		logic [LIMIT_W-1:0]       max_output;
		logic [LIMIT_W-1:0]       integral_limit;
		logic [WINDOW_W-1:0]      error_window;
		logic [WINDOW_W-1:0]      dead_zone;
	} cfg_t;

endpackage

/* hdl/pdc_in_if.sv */
// pdc_in_if: valid/ready channel carrying setpoint and measurement
// depends on nothing
interface pdc_in_if #(parameter int DATA_WIDTH = 16);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] setpoint;
	logic signed [DATA_WIDTH-1:0] measurement;

	modport source (output valid, output setpoint, output measurement, input ready);
	modport sink (input valid, input setpoint, input measurement, output ready);
endinterface

/* hdl/pdc_out_if.sv */
// pdc_out_if: valid/ready channel carrying drive and status
// depends on pdc_pkg
interface pdc_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [pdc_pkg::DRIVE_W-1:0] drive;
	logic [pdc_pkg::STATUS_W-1:0]     status;

	modport source (output valid, output drive, output status, input ready);
	modport sink (input valid, input drive, input status, output ready);
endinterface

/* hdl/pid_position_delta_controller_unit.sv */
// pid_position_delta_controller_unit: top level of one pid channel
// depends on pdc_pkg, pdc_in_if, pdc_out_if, pdc_cfg_regs, pdc_core
//
//   channel   dir   handshake        payload
//   in_ch     in    valid / ready    setpoint, measurement (DATA_WIDTH, signed)
//   out_ch    out   valid / ready    drive (16, signed), status (2)
//   cfg       in    cfg_we           cfg_index (3), cfg_wdata (24)
//
// one item per cycle sustained while out_ch is not stalled; an item passes through
// the input register for the error, then the single pass through the three
// multipliers, integral and output clamps into the result register
// arst_n clears valid flags, loop state and loads the default registers
// a stalled output holds its result while one more item waits in the input register

module pid_position_delta_controller_unit #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pdc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pdc_pkg::CFG_DW-1:0]    cfg_wdata,
	pdc_in_if.sink                        in_ch,
	pdc_out_if.source                     out_ch
);

	pdc_pkg::cfg_t cfg;

	pdc_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pdc_core #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

endmodule

/* hdl/pdc_cfg_regs.sv */
// pdc_cfg_regs: write-only configuration register file
// depends on pdc_pkg
module pdc_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pdc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pdc_pkg::CFG_DW-1:0]       cfg_wdata,
	output pdc_pkg::cfg_t                    cfg
);

	pdc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p         <= pdc_pkg::RST_GAIN_P;
			cfg_q.gain_i         <= pdc_pkg::RST_GAIN_I;
			cfg_q.gain_d         <= pdc_pkg::RST_GAIN_D;
			cfg_q.loop_mode      <= pdc_pkg::RST_LOOP_MODE;
			cfg_q.max_output     <= pdc_pkg::RST_MAX_OUTPUT;
			cfg_q.integral_limit <= pdc_pkg::RST_INT_LIMIT;
			cfg_q.error_window   <= pdc_pkg::RST_ERR_WINDOW;
			cfg_q.dead_zone      <= pdc_pkg::RST_DEAD_ZONE;
		end else if (cfg_we) begin
			unique case (pdc_pkg::reg_idx_t'(cfg_index))
				pdc_pkg::REG_GAIN_P:     cfg_q.gain_p <= cfg_wdata[pdc_pkg::GAIN_W-1:0];
				pdc_pkg::REG_GAIN_I:     cfg_q.gain_i <= cfg_wdata[pdc_pkg::GAIN_W-1:0];
				pdc_pkg::REG_GAIN_D:     cfg_q.gain_d <= cfg_wdata[pdc_pkg::GAIN_W-1:0];
				pdc_pkg::REG_LOOP_MODE:  cfg_q.loop_mode <= cfg_wdata[0];
				pdc_pkg::REG_MAX_OUTPUT: cfg_q.max_output <= cfg_wdata[pdc_pkg::LIMIT_W-1:0];
				pdc_pkg::REG_INT_LIMIT:  cfg_q.integral_limit <= cfg_wdata[pdc_pkg::LIMIT_W-1:0];
				pdc_pkg::REG_ERR_WINDOW: cfg_q.error_window <= cfg_wdata[pdc_pkg::WINDOW_W-1:0];
				pdc_pkg::REG_DEAD_ZONE:  cfg_q.dead_zone <= cfg_wdata[pdc_pkg::WINDOW_W-1:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hdl/pdc_core.sv */
// pdc_core: error input register, pid datapath with loop state, result register
// depends on pdc_pkg, pdc_in_if, pdc_out_if
module pdc_core #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  pdc_pkg::cfg_t cfg,
	pdc_in_if.sink        in_ch,
	pdc_out_if.source     out_ch
);

	localparam int EW = DATA_WIDTH + 1;                 // error
	localparam int OW = EW + 2;                         // error differences
	localparam int PW = pdc_pkg::GAIN_W + OW;           // products
	localparam int IW = pdc_pkg::LIMIT_W + FRAC_BITS + 1; // clamped values
	localparam int SW = (PW + 2 > IW + 2) ? PW + 2 : IW + 2;
	localparam int CW = (EW > pdc_pkg::WINDOW_W) ? EW : pdc_pkg::WINDOW_W;

	function automatic logic signed [SW-1:0] clamp_sym(
		input logic signed [SW-1:0]        v,
		input logic [pdc_pkg::LIMIT_W-1:0] lim
	);
		logic signed [SW-1:0] limv;
		limv = signed'(SW'(lim) << FRAC_BITS);
		if (v > limv)
			return limv;
		else if (v < -limv)
			return -limv;
		else
			return v;
	endfunction

	// input stage
	logic                 valid_s1;
	logic signed [EW-1:0] err_s1;

	// loop state
	logic signed [EW-1:0] prev_err_q;
	logic signed [EW-1:0] prev_prev_err_q;
	logic signed [IW-1:0] integ_q;
	logic signed [IW-1:0] last_out_q;

	// result register
	logic                                 out_valid_q;
	logic signed [pdc_pkg::DRIVE_W-1:0]   drive_q;
	logic [pdc_pkg::STATUS_W-1:0]         status_q;

	logic adv;
	assign adv = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv;

	// datapath
	logic [EW-1:0]                mag;
	logic                         over_window;
	logic                         in_dead_zone;
	logic [pdc_pkg::STATUS_W-1:0] status_d;
	logic signed [OW-1:0]         dd1, dd2, op_p, op_d;
	logic signed [PW-1:0]         prod_p, prod_i, prod_d;
	logic signed [SW-1:0]         integ_pre, integ_new, sum, res, res_mag;
	logic [pdc_pkg::DRIVE_W-1:0]  trunc_mag;
	logic signed [pdc_pkg::DRIVE_W-1:0] drive_d;

	always_comb begin
		mag = err_s1[EW-1] ? EW'(-err_s1) : EW'(err_s1);
		over_window = (cfg.error_window != '0) && (CW'(mag) > CW'(cfg.error_window));
		in_dead_zone = (cfg.dead_zone != '0) && (CW'(mag) < CW'(cfg.dead_zone));
		priority if (over_window)
			status_d = pdc_pkg::STATUS_WINDOW;
		else if (in_dead_zone)
			status_d = pdc_pkg::STATUS_DEAD_ZONE;
		else
			status_d = pdc_pkg::STATUS_OK;

		dd1 = OW'(err_s1) - OW'(prev_err_q);
		dd2 = OW'(err_s1) - (OW'(prev_err_q) <<< 1) + OW'(prev_prev_err_q);
		// incremental mode shifts the p and d operands by one difference order
		op_p = cfg.loop_mode ? dd1 : OW'(err_s1);
		op_d = cfg.loop_mode ? dd2 : dd1;

		prod_p = PW'(cfg.gain_p) * PW'(op_p);
		prod_i = PW'(cfg.gain_i) * PW'(err_s1);
		prod_d = PW'(cfg.gain_d) * PW'(op_d);

		integ_pre = cfg.loop_mode ? SW'(prod_i) : SW'(integ_q) + SW'(prod_i);
		integ_new = clamp_sym(integ_pre, cfg.integral_limit);
		sum = (cfg.loop_mode ? SW'(last_out_q) : SW'(0)) + SW'(prod_p) + integ_new
			+ SW'(prod_d);
		res = clamp_sym(sum, cfg.max_output);

		// truncate toward zero on the magnitude
		res_mag = res[SW-1] ? -res : res;
		trunc_mag = res_mag[FRAC_BITS +: pdc_pkg::DRIVE_W];
		drive_d = res[SW-1] ? -signed'(trunc_mag) : signed'(trunc_mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			err_s1 <= EW'(in_ch.setpoint) - EW'(in_ch.measurement);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q      <= '0;
			prev_prev_err_q <= '0;
			integ_q         <= '0;
			last_out_q      <= '0;
		end else if (adv && status_d == pdc_pkg::STATUS_OK) begin
			prev_err_q      <= err_s1;
			prev_prev_err_q <= prev_err_q;
			integ_q         <= integ_new[IW-1:0];
			if (cfg.loop_mode)
				last_out_q <= res[IW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q <= status_d;
			drive_q  <= (status_d == pdc_pkg::STATUS_OK) ? drive_d : '0;
		end
	end

	assign out_ch.valid  = out_valid_q;
	assign out_ch.drive  = drive_q;
	assign out_ch.status = status_q;

	// a rejected error leaves the loop state alone
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && status_d != pdc_pkg::STATUS_OK |=>
			$stable(integ_q) && $stable(prev_err_q) && $stable(last_out_q))
		else $error("loop state changed on a rejected error");

	// every advance lands in the result register
	assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("advanced item missing from result register");

	// an item held in the input stage is not dropped
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(err_s1))
		else $error("stalled input stage lost its item");

	// window and dead zone results carry a zero drive
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != pdc_pkg::STATUS_OK |->
			drive_q == '0 && (status_q == pdc_pkg::STATUS_WINDOW
			|| status_q == pdc_pkg::STATUS_DEAD_ZONE))
		else $error("bad status or nonzero drive on rejected error");

endmodule
